@@ sv/scb_pkg.sv @@
// ----------------------------------------------------------------------------
// scb_pkg
// Types and constants shared by the segment brush clip block.
// ----------------------------------------------------------------------------
package scb_pkg;

	localparam int ACC_W = 56;
	localparam int OPD_W = 33;
	localparam int NRM_W = 16;
	localparam int RAT_W = 18;
	localparam int FRC_W = 17;
	localparam int QUO_W = 17;

	localparam logic [1:0] KIND_SPHERE = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;

	localparam logic [2:0] REG_KIND   = 3'd0;
	localparam logic [2:0] REG_RADIUS = 3'd1;
	localparam logic [2:0] REG_MIN_X  = 3'd2;
	localparam logic [2:0] REG_MIN_Y  = 3'd3;
	localparam logic [2:0] REG_MIN_Z  = 3'd4;
	localparam logic [2:0] REG_MAX_X  = 3'd5;
	localparam logic [2:0] REG_MAX_Y  = 3'd6;
	localparam logic [2:0] REG_MAX_Z  = 3'd7;

	localparam logic signed [ACC_W-1:0] EPS_Q30   = ACC_W'(64'sd33554432);
	localparam logic signed [RAT_W-1:0] RATIO_ONE = RAT_W'(65536);
	localparam logic signed [RAT_W-1:0] RATIO_NEG_ONE = -RAT_W'(65536);
	localparam logic signed [RAT_W-1:0] RATIO_MAX = RAT_W'(131071);
	localparam logic signed [RAT_W-1:0] RATIO_MIN = -RAT_W'(131072);
	localparam logic [FRC_W-1:0] FRAC_ONE = FRC_W'(65536);
	localparam logic signed [NRM_W-1:0] NRM_ONE  = NRM_W'(16384);
	localparam logic signed [NRM_W-1:0] GROUND_Y = NRM_W'(3276);

	localparam logic [2:0] MAC_LAST = 3'd6;
	localparam logic [2:0] MAC_ENDS = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DECIDE,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic init;
		logic issue;
		logic sel;
	} mac_ctl_t;

	typedef struct packed {
		logic start;
		logic done;
		logic sat;
		logic neg;
	} div_ctl_t;

endpackage

@@ sv/scb_mac.sv @@
// ----------------------------------------------------------------------------
// scb_mac
// Shared multiply-accumulate unit for the start and end plane distances.
// ----------------------------------------------------------------------------
module scb_mac
	import scb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [ACC_W-1:0] init_val,
	input  logic signed [OPD_W-1:0] a,
	input  logic signed [NRM_W-1:0] b,
	output logic signed [ACC_W-1:0] sd,
	output logic signed [ACC_W-1:0] ed
);

	logic signed [OPD_W+NRM_W-1:0] prod_s1;
	logic                          vld_s1;
	logic                          sel_s1;
	logic signed [ACC_W-1:0]       sd_q;
	logic signed [ACC_W-1:0]       ed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sel_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			sel_s1 <= ctl.sel;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctl.init) begin
			sd_q <= init_val;
			ed_q <= init_val;
		end else if (vld_s1) begin
			if (sel_s1) begin
				ed_q <= ed_q + ACC_W'(prod_s1);
			end else begin
				sd_q <= sd_q + ACC_W'(prod_s1);
			end
		end
	end

	assign sd = sd_q;
	assign ed = ed_q;

endmodule

@@ sv/scb_div.sv @@
// ----------------------------------------------------------------------------
// scb_div
// Serial restoring divider giving a Q16 ratio magnitude with sign and saturation flags.
// ----------------------------------------------------------------------------
module scb_div
	import scb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic                    done,
	output logic                    sat,
	output logic                    neg,
	output logic [QUO_W-1:0]        quo
);

	logic [ACC_W:0]   rem_q;
	logic [ACC_W-1:0] d_q;
	logic [QUO_W-1:0] q_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             first_q;
	logic             done_q;
	logic             sat_q;
	logic             neg_q;
	logic [ACC_W:0]   two_d;
	logic [ACC_W:0]   d_ext;
	logic [ACC_W:0]   sh;

	assign two_d = {d_q, 1'b0};
	assign d_ext = {1'b0, d_q};
	assign sh    = {rem_q[ACC_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (busy_q && first_q) begin
				first_q <= 1'b0;
				cnt_q   <= 5'd16;
				if (rem_q >= two_d) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num < 0;
			rem_q <= {1'b0, (num < 0) ? ACC_W'(-num) : ACC_W'(num)};
			d_q   <= ACC_W'(den);
			q_q   <= '0;
		end else if (busy_q && first_q) begin
			sat_q <= rem_q >= two_d;
			if (rem_q >= d_ext) begin
				rem_q <= rem_q - d_ext;
				q_q   <= QUO_W'(1);
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			if (sh >= d_ext) begin
				rem_q <= sh - d_ext;
				q_q   <= {q_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q   <= {q_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign neg  = neg_q;
	assign quo  = q_q;

endmodule

@@ sv/segment_convex_brush_clip_top.sv @@
// ----------------------------------------------------------------------------
// segment_convex_brush_clip_top
// Clips a ray, sphere or box segment against a convex brush, one side a beat.
// ----------------------------------------------------------------------------
// Each input beat carries one side plane. Per beat, the shared multiplier
// forms six products, a decision state follows, then the serial ratio
// divider, an update state and a finish state. A new beat is taken only in
// idle. The divider stops early on a side whose ratio saturates. A side that
// cuts nothing skips the divider and the update. A side that follows an
// early out goes straight to finish. A result beat is sent on each last side,
// and the block holds there until the previous result is taken.
module segment_convex_brush_clip_top
	import scb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, normal_x, normal_y,
	// normal_z, plane_distance
	input  logic [271:0] s_tdata,
	input  logic         s_tuser, // new_trace
	input  logic         s_tlast, // last_side
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_fraction, collided, try_step, grounded, hit_normal_x, hit_normal_y,
	// hit_normal_z, zero pad
	output logic [71:0]  m_tdata
);

	logic [1:0]              kind_q;
	logic [30:0]             radius_q;
	logic signed [31:0]      bmin_q [3];
	logic signed [31:0]      bmax_q [3];

	state_t                  state_q, state_d;
	logic [2:0]              cnt_q;
	logic signed [OPD_W-1:0] sa_q [3];
	logic signed [OPD_W-1:0] ea_q [3];
	logic signed [NRM_W-1:0] n_q [3];
	logic                    last_q;
	logic                    moved_q;
	logic signed [ACC_W-1:0] init_q;

	logic signed [RAT_W-1:0] entry_q, exit_q;
	logic                    outside_q, skipped_q;
	logic [FRC_W-1:0]        frac_q;
	logic                    hit_q, step_q, ground_q;
	logic signed [NRM_W-1:0] snrm_q [3];
	logic                    is_entry_q;
	logic signed [ACC_W-1:0] num_d, den_d;
	logic signed [RAT_W-1:0] r_q;
	logic                    mv_q;
	logic [71:0]             out_q;

	mac_ctl_t                mac_ctl;
	div_ctl_t                div_ctl;
	logic signed [OPD_W-1:0] mac_a;
	logic signed [NRM_W-1:0] mac_b;
	logic signed [ACC_W-1:0] sd, ed;
	logic [QUO_W-1:0]        quo;
	logic signed [RAT_W-1:0] r_d;
	logic                    accept;
	logic                    out_free;
	logic signed [33:0]      dist_eff;
	logic signed [31:0]      in_s [3];
	logic signed [31:0]      in_e [3];
	logic signed [NRM_W-1:0] in_n [3];
	logic signed [31:0]      off  [3];

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_s[i] = s_tdata[32*i +: 32];
			in_e[i] = s_tdata[96 + 32*i +: 32];
			in_n[i] = s_tdata[192 + 16*i +: 16];
			off[i]  = (kind_q == KIND_BOX) ? ((in_n[i] < 0) ? bmax_q[i] : bmin_q[i]) : 32'sd0;
		end
		dist_eff = 34'(signed'(s_tdata[271:240]));
		if (kind_q == KIND_SPHERE) begin
			dist_eff = dist_eff + 34'(signed'({1'b0, radius_q}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			radius_q <= '0;
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= '0;
				bmax_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KIND:   kind_q    <= cfg_data[1:0];
				REG_RADIUS: radius_q  <= cfg_data[30:0];
				REG_MIN_X:  bmin_q[0] <= cfg_data;
				REG_MIN_Y:  bmin_q[1] <= cfg_data;
				REG_MIN_Z:  bmin_q[2] <= cfg_data;
				REG_MAX_X:  bmax_q[0] <= cfg_data;
				REG_MAX_Y:  bmax_q[1] <= cfg_data;
				REG_MAX_Z:  bmax_q[2] <= cfg_data;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = skipped_q ? ST_FINISH : ST_MAC;
				end
			end
			ST_MAC: begin
				if (cnt_q == MAC_LAST) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if ((sd > 0 && ed > 0) || (sd <= 0 && ed <= 0)) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_ctl.done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!last_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = state_q == ST_IDLE;
		mac_ctl.init  = state_q == ST_MAC && cnt_q == '0;
		mac_ctl.issue = state_q == ST_MAC && cnt_q < MAC_LAST;
		mac_ctl.sel   = cnt_q >= MAC_ENDS;
		div_ctl.start = state_q == ST_DECIDE && state_d == ST_DIV;
	end

	always_comb begin
		mac_a = sa_q[0];
		mac_b = n_q[0];
		unique case (cnt_q)
			3'd0: begin mac_a = sa_q[0]; mac_b = n_q[0]; end
			3'd1: begin mac_a = sa_q[1]; mac_b = n_q[1]; end
			3'd2: begin mac_a = sa_q[2]; mac_b = n_q[2]; end
			3'd3: begin mac_a = ea_q[0]; mac_b = n_q[0]; end
			3'd4: begin mac_a = ea_q[1]; mac_b = n_q[1]; end
			3'd5: begin mac_a = ea_q[2]; mac_b = n_q[2]; end
			default: begin mac_a = sa_q[0]; mac_b = n_q[0]; end
		endcase
	end

	always_comb begin
		if (sd > ed) begin
			num_d = sd - EPS_Q30;
			den_d = sd - ed;
		end else begin
			num_d = -(sd + EPS_Q30);
			den_d = ed - sd;
		end
	end

	scb_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.init_val (init_q),
		.a        (mac_a),
		.b        (mac_b),
		.sd       (sd),
		.ed       (ed)
	);

	scb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_ctl.start),
		.num    (num_d),
		.den    (den_d),
		.done   (div_ctl.done),
		.sat    (div_ctl.sat),
		.neg    (div_ctl.neg),
		.quo    (quo)
	);

	always_comb begin
		if (div_ctl.sat) begin
			r_d = div_ctl.neg ? RATIO_MIN : RATIO_MAX;
		end else if (div_ctl.neg) begin
			r_d = -RAT_W'(quo);
		end else begin
			r_d = RAT_W'(quo);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				sa_q[i] <= OPD_W'(in_s[i]) + OPD_W'(off[i]);
				ea_q[i] <= OPD_W'(in_e[i]) + OPD_W'(off[i]);
				n_q[i]  <= in_n[i];
			end
			moved_q <= (in_s[0] != in_e[0]) || (in_s[2] != in_e[2]);
			init_q  <= -(ACC_W'(dist_eff) <<< 14);
		end
		if (state_q == ST_DECIDE) begin
			is_entry_q <= sd > ed;
		end
		if (div_ctl.done) begin
			r_q <= r_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			entry_q   <= RATIO_NEG_ONE;
			exit_q    <= RATIO_ONE;
			outside_q <= 1'b0;
			skipped_q <= 1'b0;
			frac_q    <= FRAC_ONE;
			hit_q     <= 1'b0;
			step_q    <= 1'b0;
			ground_q  <= 1'b0;
			mv_q      <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				snrm_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= '0;
				last_q <= s_tlast;
				if (s_tuser) begin
					frac_q   <= FRAC_ONE;
					hit_q    <= 1'b0;
					step_q   <= 1'b0;
					ground_q <= 1'b0;
				end
			end else if (state_q == ST_MAC) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (state_q == ST_DECIDE) begin
				if (sd > 0) begin
					outside_q <= 1'b1;
				end
				if (sd > 0 && ed > 0) begin
					skipped_q <= 1'b1;
				end
			end
			if (state_q == ST_UPDATE) begin
				if (is_entry_q) begin
					if (r_q > entry_q) begin
						entry_q <= r_q;
						hit_q   <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							snrm_q[i] <= n_q[i];
						end
						if (moved_q && n_q[1] != NRM_ONE) begin
							step_q <= 1'b1;
						end
						if (n_q[1] > GROUND_Y) begin
							ground_q <= 1'b1;
						end
					end
				end else if (r_q < exit_q) begin
					exit_q <= r_q;
				end
			end
			if (state_q == ST_FINISH && last_q && out_free) begin
				if (!skipped_q && outside_q && entry_q < exit_q && entry_q > RATIO_NEG_ONE
					&& 19'(entry_q) < signed'({2'b00, frac_q})) begin
					frac_q <= (entry_q < 0) ? '0 : FRC_W'(entry_q);
				end
				entry_q   <= RATIO_NEG_ONE;
				exit_q    <= RATIO_ONE;
				outside_q <= 1'b0;
				skipped_q <= 1'b0;
			end
			if (state_q == ST_FINISH && last_q && out_free) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && last_q && out_free) begin
			out_q <= {4'b0000, snrm_q[2], snrm_q[1], snrm_q[0], ground_q, step_q, hit_q,
				(!skipped_q && outside_q && entry_q < exit_q && entry_q > RATIO_NEG_ONE
				&& 19'(entry_q) < signed'({2'b00, frac_q}))
				? ((entry_q < 0) ? FRC_W'(0) : FRC_W'(entry_q)) : frac_q};
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted while busy");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> state_q == ST_DIV)
		else $error("divider finished outside its state");

	a_brush_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && last_q && out_free)
		|=> (!skipped_q && !outside_q && entry_q == RATIO_NEG_ONE && exit_q == RATIO_ONE))
		else $error("brush state not cleared after last side");

endmodule
